### rtl/assert_macros.svh
// assertion macros used by nearest_palette_color_lookup_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every rising clock edge outside reset
`define NPCL_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("npcl assertion failed");

// expression must never be true outside reset
`define NPCL_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("npcl forbidden condition seen");

`else

`define NPCL_ASSERT(lbl, clk, rstn, prop)

`define NPCL_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

### rtl/npcl_pkg.sv
`timescale 1ns / 1ps

package npcl_pkg;

    // sizes
    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int CHAN_W            = 16;
    localparam int QUERY_W           = 5;
    localparam int DIST_W            = 18;
    localparam int CFG_IDX_W         = 4;
    localparam int CFG_DATA_W        = 9;

    // distance seed, above any reachable sum of three channel differences
    localparam logic [DIST_W-1:0] START_DISTANCE = 18'd196608;
    localparam logic [7:0]        NO_MATCH_INDEX = 8'hFF;
    localparam logic [2:0]        PREC_MAX       = 3'd5;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_USE_PALETTE   = 4'd0,
        REG_PALETTE_COUNT = 4'd1,
        REG_RED_PREC      = 4'd2,
        REG_RED_POS       = 4'd3,
        REG_GREEN_PREC    = 4'd4,
        REG_GREEN_POS     = 4'd5,
        REG_BLUE_PREC     = 4'd6,
        REG_BLUE_POS      = 4'd7
    } cfg_reg_t;

    // item opcodes
    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_LOOKUP = 1'b1
    } opcode_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_DRAIN = 2'd2,
        ST_EMIT  = 2'd3
    } fsm_state_t;

    // input beat
    typedef struct packed {
        logic               opcode;
        logic [7:0]         entry_slot;
        logic [CHAN_W-1:0]  entry_red;
        logic [CHAN_W-1:0]  entry_green;
        logic [CHAN_W-1:0]  entry_blue;
        logic [QUERY_W-1:0] query_red;
        logic [QUERY_W-1:0] query_green;
        logic [QUERY_W-1:0] query_blue;
    } in_item_t;

    // result beat
    typedef struct packed {
        logic [7:0] color_index;
        logic       no_match;
    } out_item_t;

    // one palette entry
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } palette_entry_t;

    // sequencer to distance unit
    typedef struct packed {
        logic start;
        logic valid;
    } dist_ctl_t;

    // distance unit to sequencer
    typedef struct packed {
        logic busy;
        logic found;
    } dist_sts_t;

    // 5-bit channel to 16 bits: replicate to 8 bits, low byte zero
    function automatic logic [CHAN_W-1:0] widen(input logic [QUERY_W-1:0] c);
        return {c, c[4:2], 8'h00};
    endfunction

    // true-color packing of one channel
    function automatic logic [7:0] pack_channel(input logic [QUERY_W-1:0] c,
                                                input logic [2:0] prec,
                                                input logic [2:0] pos);
        logic [2:0] p;
        logic [2:0] rsh;
        logic [7:0] v;
        p   = (prec > PREC_MAX) ? PREC_MAX : prec;
        rsh = PREC_MAX - p;
        v   = {3'b000, c} >> rsh;
        return v << pos;
    endfunction

endpackage

### rtl/npcl_palette_mem.sv
`timescale 1ns / 1ps

module npcl_palette_mem #(
    parameter int PALETTE_DEPTH = npcl_pkg::PALETTE_DEPTH_DEF,
    parameter int AW            = $clog2(PALETTE_DEPTH)
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  npcl_pkg::palette_entry_t wr_data,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output npcl_pkg::palette_entry_t rd_data
);

    npcl_pkg::palette_entry_t mem [PALETTE_DEPTH];
    npcl_pkg::palette_entry_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/npcl_dist_unit.sv
`timescale 1ns / 1ps

module npcl_dist_unit #(
    parameter int AW = $clog2(npcl_pkg::PALETTE_DEPTH_DEF)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  npcl_pkg::dist_ctl_t      ctl,
    input  npcl_pkg::palette_entry_t entry,
    input  logic [AW-1:0]            entry_idx,
    input  npcl_pkg::palette_entry_t query,
    output npcl_pkg::dist_sts_t      sts,
    output logic [AW-1:0]            best_idx
);

    localparam int DW = npcl_pkg::DIST_W;
    localparam int CW = npcl_pkg::CHAN_W;

    logic [CW-1:0] diff_r_reg, diff_g_reg, diff_b_reg;
    logic          diff_vld_reg;
    logic [AW-1:0] diff_idx_reg;
    logic [DW-1:0] sum_reg;
    logic          sum_vld_reg;
    logic [AW-1:0] sum_idx_reg;
    logic [DW-1:0] best_reg;
    logic [AW-1:0] best_idx_reg;
    logic          found_reg;

    logic [CW-1:0] diff_r, diff_g, diff_b;
    logic [DW-1:0] sum_next;

    // absolute channel differences
    always_comb begin
        diff_r = (query.red   >= entry.red)   ? query.red   - entry.red
                                              : entry.red   - query.red;
        diff_g = (query.green >= entry.green) ? query.green - entry.green
                                              : entry.green - query.green;
        diff_b = (query.blue  >= entry.blue)  ? query.blue  - entry.blue
                                              : entry.blue  - query.blue;
    end

    assign sum_next = DW'(diff_r_reg) + DW'(diff_g_reg) + DW'(diff_b_reg);

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_vld_reg <= 1'b0;
            sum_vld_reg  <= 1'b0;
        end else begin
            diff_vld_reg <= ctl.valid;
            sum_vld_reg  <= diff_vld_reg;
        end
    end

    // difference and sum stages
    always_ff @(posedge aclk) begin
        diff_r_reg   <= diff_r;
        diff_g_reg   <= diff_g;
        diff_b_reg   <= diff_b;
        diff_idx_reg <= entry_idx;
        sum_reg      <= sum_next;
        sum_idx_reg  <= diff_idx_reg;
    end

    // running minimum, earliest entry kept on ties
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctl.start) begin
            found_reg <= 1'b0;
        end else if (sum_vld_reg && (sum_reg < best_reg)) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            best_reg <= npcl_pkg::START_DISTANCE;
        end else if (sum_vld_reg && (sum_reg < best_reg)) begin
            best_reg     <= sum_reg;
            best_idx_reg <= sum_idx_reg;
        end
    end

    assign sts.busy  = diff_vld_reg | sum_vld_reg;
    assign sts.found = found_reg;
    assign best_idx  = best_idx_reg;

endmodule

### rtl/nearest_palette_color_lookup_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Nearest palette color lookup. Load beats (opcode 0) write one 48-bit palette
// entry and give no result. Lookup beats (opcode 1) give one result beat. In
// true-color mode, or in palette mode with palette_count zero, a lookup sets
// its result directly without a scan. In palette mode a lookup scans
// n = min(palette_count, PALETTE_DEPTH) entries; the palette memory has
// one read port, so the scan reads one entry per cycle into a shared
// three-stage distance unit (difference, sum, compare) and then drains it.
// s_ready is low from the accepted lookup until its result is loaded into the
// output register; cfg writes are taken at any time and must only be issued
// while the block is idle. Palette entries come up undefined after reset and
// must be loaded before a lookup scans them.
module nearest_palette_color_lookup_unit #(
    parameter int PALETTE_DEPTH = npcl_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  npcl_pkg::in_item_t                  s_payload,
    output logic                                m_valid,
    input  logic                                m_ready,
    output npcl_pkg::out_item_t                 m_payload,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [npcl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [npcl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int CW = $clog2(PALETTE_DEPTH + 1);

    // configuration registers
    logic       use_palette_reg;
    logic [8:0] palette_count_reg;
    logic [2:0] red_prec_reg, red_pos_reg;
    logic [2:0] green_prec_reg, green_pos_reg;
    logic [2:0] blue_prec_reg, blue_pos_reg;

    npcl_pkg::fsm_state_t     state_reg, state_next;
    logic [CW-1:0]            rd_cnt_reg;
    logic [CW-1:0]            n_last_reg;
    logic                     rd_vld_reg;
    logic [AW-1:0]            rd_idx_reg;
    npcl_pkg::palette_entry_t query_reg;
    npcl_pkg::out_item_t      res_reg;
    npcl_pkg::out_item_t      m_item_reg;
    logic                     m_valid_reg;

    logic                     s_beat, cfg_beat, is_lookup, load_we, empty;
    logic                     rd_en, res_direct, res_scan, out_load;
    logic [CW-1:0]            n_sat;
    npcl_pkg::dist_ctl_t      dist_ctl;
    npcl_pkg::dist_sts_t      dist_sts;
    npcl_pkg::palette_entry_t wr_entry, rd_entry;
    logic [AW-1:0]            best_idx;
    logic [7:0]               packed_color;

    assign cfg_ready = 1'b1;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign s_ready   = (state_reg == npcl_pkg::ST_IDLE);
    assign s_beat    = s_valid && s_ready;
    assign is_lookup = (s_payload.opcode == npcl_pkg::OP_LOOKUP);
    assign load_we   = s_beat && !is_lookup &&
                       ({1'b0, s_payload.entry_slot} < 9'(PALETTE_DEPTH));
    assign empty     = (palette_count_reg == 9'd0);
    assign n_sat     = (palette_count_reg > 9'(PALETTE_DEPTH)) ? CW'(PALETTE_DEPTH)
                                                               : CW'(palette_count_reg);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_palette_reg   <= 1'b1;
            palette_count_reg <= 9'd0;
            red_prec_reg      <= 3'd3;
            red_pos_reg       <= 3'd5;
            green_prec_reg    <= 3'd3;
            green_pos_reg     <= 3'd2;
            blue_prec_reg     <= 3'd2;
            blue_pos_reg      <= 3'd0;
        end else if (cfg_beat) begin
            case (npcl_pkg::cfg_reg_t'(cfg_index))
                npcl_pkg::REG_USE_PALETTE:   use_palette_reg   <= cfg_data[0];
                npcl_pkg::REG_PALETTE_COUNT: palette_count_reg <= cfg_data;
                npcl_pkg::REG_RED_PREC:      red_prec_reg      <= cfg_data[2:0];
                npcl_pkg::REG_RED_POS:       red_pos_reg       <= cfg_data[2:0];
                npcl_pkg::REG_GREEN_PREC:    green_prec_reg    <= cfg_data[2:0];
                npcl_pkg::REG_GREEN_POS:     green_pos_reg     <= cfg_data[2:0];
                npcl_pkg::REG_BLUE_PREC:     blue_prec_reg     <= cfg_data[2:0];
                npcl_pkg::REG_BLUE_POS:      blue_pos_reg      <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // true-color packing
    assign packed_color =
        npcl_pkg::pack_channel(s_payload.query_red,   red_prec_reg,   red_pos_reg)   |
        npcl_pkg::pack_channel(s_payload.query_green, green_prec_reg, green_pos_reg) |
        npcl_pkg::pack_channel(s_payload.query_blue,  blue_prec_reg,  blue_pos_reg);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        rd_en          = 1'b0;
        res_direct     = 1'b0;
        res_scan       = 1'b0;
        out_load       = 1'b0;
        dist_ctl.start = 1'b0;
        dist_ctl.valid = rd_vld_reg;
        case (state_reg)
            npcl_pkg::ST_IDLE: begin
                if (s_beat && is_lookup) begin
                    if (!use_palette_reg || empty) begin
                        res_direct = 1'b1;
                        state_next = npcl_pkg::ST_EMIT;
                    end else begin
                        dist_ctl.start = 1'b1;
                        state_next     = npcl_pkg::ST_SCAN;
                    end
                end
            end
            npcl_pkg::ST_SCAN: begin
                rd_en = 1'b1;
                if (rd_cnt_reg == n_last_reg) begin
                    state_next = npcl_pkg::ST_DRAIN;
                end
            end
            npcl_pkg::ST_DRAIN: begin
                if (!rd_vld_reg && !dist_sts.busy) begin
                    res_scan   = 1'b1;
                    state_next = npcl_pkg::ST_EMIT;
                end
            end
            npcl_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = npcl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = npcl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= npcl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // scan address counter and read tag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (dist_ctl.start) begin
            rd_cnt_reg <= '0;
            n_last_reg <= n_sat - CW'(1);
            query_reg  <= '{red:   npcl_pkg::widen(s_payload.query_red),
                           green: npcl_pkg::widen(s_payload.query_green),
                           blue:  npcl_pkg::widen(s_payload.query_blue)};
        end else if (rd_en) begin
            rd_cnt_reg <= rd_cnt_reg + CW'(1);
        end
        rd_idx_reg <= rd_cnt_reg[AW-1:0];
    end

    // pending result
    always_ff @(posedge aclk) begin
        if (res_direct) begin
            res_reg.color_index <= use_palette_reg ? npcl_pkg::NO_MATCH_INDEX : packed_color;
            res_reg.no_match    <= use_palette_reg;
        end else if (res_scan) begin
            res_reg.color_index <= dist_sts.found ? 8'(best_idx) : npcl_pkg::NO_MATCH_INDEX;
            res_reg.no_match    <= !dist_sts.found;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_item_reg <= res_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_item_reg;

    // palette load path
    assign wr_entry = '{red:   s_payload.entry_red,
                        green: s_payload.entry_green,
                        blue:  s_payload.entry_blue};

    npcl_palette_mem #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .AW            (AW)
    ) u_palette_mem (
        .aclk    (aclk),
        .wr_en   (load_we),
        .wr_addr (s_payload.entry_slot[AW-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_cnt_reg[AW-1:0]),
        .rd_data (rd_entry)
    );

    npcl_dist_unit #(
        .AW (AW)
    ) u_dist_unit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (dist_ctl),
        .entry     (rd_entry),
        .entry_idx (rd_idx_reg),
        .query     (query_reg),
        .sts       (dist_sts),
        .best_idx  (best_idx)
    );

    // checks
    `NPCL_ASSERT(a_rise_from_emit, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg == npcl_pkg::ST_EMIT))
    `NPCL_ASSERT(a_scan_in_range, aclk, aresetn, (state_reg == npcl_pkg::ST_SCAN) |-> (rd_cnt_reg <= n_last_reg))
    `NPCL_ASSERT_NEVER(a_idle_pipe_empty, aclk, aresetn, (state_reg == npcl_pkg::ST_IDLE) && (rd_vld_reg || dist_sts.busy))
    `NPCL_ASSERT(a_no_match_index, aclk, aresetn, (m_valid_reg && m_item_reg.no_match) |-> (m_item_reg.color_index == npcl_pkg::NO_MATCH_INDEX))

endmodule
